// ===== hw/rtl/json_token_validator_unit_assert.svh =====
// Assertion macros for the JSON token validator checker.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef JSON_TOKEN_VALIDATOR_UNIT_ASSERT_SVH
`define JSON_TOKEN_VALIDATOR_UNIT_ASSERT_SVH
// Implication in the same cycle.
`define JTV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jtv assertion failed");
// Implication in the next cycle.
`define JTV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jtv assertion failed");
`endif

// ===== hw/rtl/jtv_pkg.sv =====
// Package for the JSON token validator: types, codes, constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package jtv_pkg;
  localparam int NEST_DEPTH_DEF = 32;
  localparam int POS_BITS_DEF = 16;
  localparam int MAX_RES = 3;

  typedef enum logic [4:0] {
    M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER, M_LIT,
    M_SIGN, M_INT, M_ZERO, M_DOT, M_FRAC, M_STR, M_IDLE
  } mode_t;

  localparam logic [3:0] TK_NONE = 4'd0;
  localparam logic [3:0] TK_INT = 4'd4;
  localparam logic [3:0] TK_FRAC = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_KEY = 4'd7;
  localparam logic [3:0] TK_ARR_OPEN = 4'd8;
  localparam logic [3:0] TK_ARR_CLOSE = 4'd9;
  localparam logic [3:0] TK_OBJ_OPEN = 4'd10;
  localparam logic [3:0] TK_OBJ_CLOSE = 4'd11;

  localparam logic [3:0] ER_OK = 4'd0;
  localparam logic [3:0] ER_END = 4'd1;
  localparam logic [3:0] ER_START = 4'd2;
  localparam logic [3:0] ER_NULL = 4'd3;
  localparam logic [3:0] ER_BOOL = 4'd4;
  localparam logic [3:0] ER_DIGIT = 4'd5;
  localparam logic [3:0] ER_FRAC = 4'd6;
  localparam logic [3:0] ER_STRING = 4'd7;
  localparam logic [3:0] ER_ARR_SEP = 4'd8;
  localparam logic [3:0] ER_OBJ_QUOTE = 4'd9;
  localparam logic [3:0] ER_OBJ_COLON = 4'd10;
  localparam logic [3:0] ER_OBJ_SEP = 4'd11;
  localparam logic [3:0] ER_DEPTH = 4'd12;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [3:0] error_code;
    logic signed [31:0] int_value;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic document_done;
  } res_t;

  function automatic res_t mk_res(logic [3:0] kind, logic [3:0] err, logic [31:0] val,
                                  logic [15:0] start, logic [15:0] len, logic done);
    res_t r;
    r.token_kind = kind;
    r.error_code = err;
    r.int_value = val;
    r.span_start = start;
    r.span_length = len;
    r.document_done = done;
    return r;
  endfunction

  // Literal texts: null, true, false.
  function automatic logic [7:0] lit_char(logic [1:0] idx, logic [2:0] prog);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      2'd1: begin
        case (prog)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (prog)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (prog)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] idx);
    return (idx == 2'd2) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [3:0] lit_err(logic [1:0] idx);
    return (idx == 2'd0) ? ER_NULL : ER_BOOL;
  endfunction
endpackage

// ===== hw/rtl/jtv_if.sv =====
// Channel interfaces of the JSON token validator: byte input and result output.
// No dependencies.
`timescale 1ns / 1ps
interface jtv_in_if;
  logic valid;
  logic ready;
  logic [7:0] char_byte;
  logic end_of_input;
  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink (input valid, char_byte, end_of_input, output ready);
endinterface

interface jtv_out_if;
  logic valid;
  logic ready;
  logic [3:0] token_kind;
  logic [3:0] error_code;
  logic signed [31:0] int_value;
  logic [15:0] span_start;
  logic [15:0] span_length;
  logic document_done;
  logic last_of_run;
  modport source (output valid, token_kind, error_code, int_value, span_start, span_length,
                  document_done, last_of_run, input ready);
  modport sink (input valid, token_kind, error_code, int_value, span_start, span_length,
                document_done, last_of_run, output ready);
endinterface

// ===== hw/rtl/json_token_validator_unit.sv =====
// Top level of the JSON token validator: byte channel in, token event channel out.
// Depends on jtv_pkg, jtv_if, jtv_parser and jtv_outq.
//
// The in_ch channel carries one document byte per item with an end flag. The out_ch
// channel carries token and error events; each byte gives zero to three results, and
// last_of_run marks the final result of a byte.
// The results of a byte appear in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and out_ch.ready
// stays high; a byte with more results holds in_ch until the single result register bank drains.
// The next byte is taken in the cycle its predecessor's final result is taken.
// When the receiver stalls, results hold and in_ch.ready falls once the bank is full.
// Reset empties the result bank and returns the parser to expecting a top-level value
// at offset zero; the container stack needs no clearing. The byte that carries the end
// flag also returns all parser state to its reset value.
`timescale 1ns / 1ps
module json_token_validator_unit import jtv_pkg::*; #(
  parameter int NEST_DEPTH = NEST_DEPTH_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  jtv_in_if.sink in_ch,
  jtv_out_if.source out_ch
);
  res_t res [MAX_RES];
  res_t out_res;
  logic [1:0] res_cnt;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;

  jtv_parser #(.NEST_DEPTH(NEST_DEPTH), .POSITION_BITS(POSITION_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n), .accept(accept), .char_byte(in_ch.char_byte),
    .end_of_input(in_ch.end_of_input), .res(res), .res_cnt(res_cnt)
  );

  jtv_outq u_outq (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res(res), .res_cnt(res_cnt), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_res(out_res), .out_last(out_ch.last_of_run)
  );

  assign out_ch.token_kind = out_res.token_kind;
  assign out_ch.error_code = out_res.error_code;
  assign out_ch.int_value = out_res.int_value;
  assign out_ch.span_start = out_res.span_start;
  assign out_ch.span_length = out_res.span_length;
  assign out_ch.document_done = out_res.document_done;
endmodule

// ===== hw/rtl/jtv_parser.sv =====
// Parser state registers and the per-byte next-state and result logic.
// Depends on jtv_pkg.
`timescale 1ns / 1ps
module jtv_parser import jtv_pkg::*; #(
  parameter int NEST_DEPTH = NEST_DEPTH_DEF,
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output res_t       res [MAX_RES],
  output logic [1:0] res_cnt
);
  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int IW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
  localparam int PB = POSITION_BITS;

  mode_t mode_r, mode_nxt;
  logic [2:0] prog_r, prog_nxt;
  logic [NEST_DEPTH-1:0] kinds_r;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [1:0] exp_r, exp_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [PB-1:0] beg_r, beg_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic minus_r, minus_nxt;
  logic [2:0] esc_r, esc_nxt;
  logic fof_r, fof_nxt;
  logic kwr_en;
  logic [IW-1:0] kwr_idx;
  logic kwr_val;

  logic [PB-1:0] pos, endpos, num_len;
  logic [LW-1:0] lvl_m1;
  logic [1:0] lidx;
  logic [35:0] acc_wide;
  logic [31:0] num_val;
  logic isdig, blank, do_wait, is_obj, do_close, close_obj, do_str, str_key, do_open, open_obj;
  logic num_end, do_fail;
  logic [3:0] fail_code;

  always_comb begin
    pos = pos_r;
    endpos = pos_r + PB'(1);
    mode_nxt = mode_r;
    prog_nxt = prog_r;
    lvl_nxt = lvl_r;
    exp_nxt = exp_r;
    pos_nxt = endpos;
    beg_nxt = beg_r;
    acc_nxt = acc_r;
    minus_nxt = minus_r;
    esc_nxt = esc_r;
    fof_nxt = fof_r;
    kwr_en = 1'b0;
    kwr_idx = lvl_r[IW-1:0];
    kwr_val = 1'b0;
    res_cnt = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = mk_res(TK_NONE, ER_OK, 32'd0, 16'd0, 16'd0, 1'b0);
    end
    isdig = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
    blank = (char_byte == CH_SPACE) || (char_byte == CH_CR) || (char_byte == CH_LF) ||
            (char_byte == CH_TAB);
    do_wait = 1'b0;
    num_end = 1'b0;
    do_fail = 1'b0;
    fail_code = ER_OK;
    lidx = (exp_r < 2'd3) ? exp_r : 2'd0;
    acc_wide = {4'd0, acc_r} * 36'd10 + 36'(char_byte - CH_ZERO);
    is_obj = 1'b0;
    do_close = 1'b0;
    close_obj = 1'b0;
    do_str = 1'b0;
    str_key = 1'b0;
    do_open = 1'b0;
    open_obj = 1'b0;
    lvl_m1 = '0;
    num_val = 32'd0;
    num_len = '0;

    if (!fof_r) begin
      case (mode_r)
        M_LIT: begin
          if (prog_r < lit_len(lidx) && char_byte == lit_char(lidx, prog_r)) begin
            prog_nxt = prog_r + 3'd1;
            if (prog_nxt == lit_len(lidx)) begin
              res[res_cnt] = mk_res(4'(lidx) + 4'd1, ER_OK, 32'd0, 16'(beg_r),
                                    16'(lit_len(lidx)), lvl_r == '0);
              res_cnt = res_cnt + 2'd1;
              if (lvl_r == '0) begin
                fof_nxt = 1'b1;
                mode_nxt = M_IDLE;
              end else begin
                mode_nxt = M_AFTER;
              end
            end
          end else begin
            do_fail = 1'b1;
            fail_code = lit_err(lidx);
          end
        end
        M_SIGN: begin
          if (char_byte == CH_ZERO) begin
            mode_nxt = M_ZERO;
          end else if (isdig) begin
            acc_nxt = 32'(char_byte - CH_ZERO);
            mode_nxt = M_INT;
          end else begin
            do_fail = 1'b1;
            fail_code = ER_DIGIT;
          end
        end
        M_INT, M_ZERO: begin
          if (mode_r == M_INT && isdig) begin
            acc_nxt = (acc_wide > 36'h080000000) ? 32'h80000000 : acc_wide[31:0];
          end else if (char_byte == CH_DOT) begin
            mode_nxt = M_DOT;
          end else begin
            num_end = 1'b1;
            do_wait = 1'b1;
          end
        end
        M_DOT: begin
          if (isdig) begin
            mode_nxt = M_FRAC;
          end else begin
            do_fail = 1'b1;
            fail_code = ER_FRAC;
          end
        end
        M_FRAC: begin
          if (!isdig) begin
            num_end = 1'b1;
            do_wait = 1'b1;
          end
        end
        M_STR: begin
          if (esc_r == 3'd5) begin
            esc_nxt = (char_byte == CH_LC_U) ? 3'd4 : 3'd0;
          end else if (esc_r != 3'd0) begin
            esc_nxt = esc_r - 3'd1;
          end else if (char_byte == CH_BSLASH) begin
            esc_nxt = 3'd5;
          end else if (char_byte == CH_QUOTE) begin
            if (exp_r == 2'd1) begin
              res[res_cnt] = mk_res(TK_KEY, ER_OK, 32'd0, 16'(beg_r), 16'(pos - beg_r), 1'b0);
              res_cnt = res_cnt + 2'd1;
              mode_nxt = M_COLON;
            end else begin
              res[res_cnt] = mk_res(TK_STRING, ER_OK, 32'd0, 16'(beg_r), 16'(pos - beg_r),
                                    lvl_r == '0);
              res_cnt = res_cnt + 2'd1;
              if (lvl_r == '0) begin
                fof_nxt = 1'b1;
                mode_nxt = M_IDLE;
              end else begin
                mode_nxt = M_AFTER;
              end
            end
          end
        end
        M_IDLE: begin
        end
        default: begin
          do_wait = 1'b1;
        end
      endcase
    end

    if (num_end) begin
      num_val = minus_r ? (32'd0 - acc_r) : ((acc_r > 32'h7FFFFFFF) ? 32'h7FFFFFFF : acc_r);
      num_len = pos - beg_r;
      res[res_cnt] = mk_res((mode_r == M_FRAC) ? TK_FRAC : TK_INT, ER_OK,
                            (mode_r == M_FRAC) ? 32'd0 : num_val, 16'(beg_r), 16'(num_len),
                            lvl_r == '0);
      res_cnt = res_cnt + 2'd1;
      if (lvl_r == '0) begin
        fof_nxt = 1'b1;
        mode_nxt = M_IDLE;
      end else begin
        mode_nxt = M_AFTER;
      end
    end

    if (do_wait && !fof_nxt && !blank) begin
      case (mode_nxt)
        M_VALUE: begin
          do_open = 1'b1;
        end
        M_ARR_FIRST: begin
          if (char_byte == CH_RBRACK) begin
            do_close = 1'b1;
          end else begin
            do_open = 1'b1;
          end
        end
        M_OBJ_FIRST, M_KEY: begin
          if (mode_nxt == M_OBJ_FIRST && char_byte == CH_RBRACE) begin
            do_close = 1'b1;
            close_obj = 1'b1;
          end else if (char_byte == CH_QUOTE) begin
            do_str = 1'b1;
            str_key = 1'b1;
          end else begin
            do_fail = 1'b1;
            fail_code = ER_OBJ_QUOTE;
          end
        end
        M_COLON: begin
          if (char_byte == CH_COLON) begin
            mode_nxt = M_VALUE;
          end else begin
            do_fail = 1'b1;
            fail_code = ER_OBJ_COLON;
          end
        end
        M_AFTER: begin
          lvl_m1 = lvl_r - LW'(1);
          is_obj = (lvl_r != '0) ? kinds_r[lvl_m1[IW-1:0]] : 1'b0;
          if (char_byte == (is_obj ? CH_RBRACE : CH_RBRACK)) begin
            do_close = 1'b1;
            close_obj = is_obj;
          end else if (char_byte == CH_COMMA) begin
            mode_nxt = is_obj ? M_KEY : M_VALUE;
          end else begin
            do_fail = 1'b1;
            fail_code = is_obj ? ER_OBJ_SEP : ER_ARR_SEP;
          end
        end
        default: begin
        end
      endcase
    end

    // Start of a value: literal, number, string or container opener, else an ER_START error.
    if (do_open) begin
      beg_nxt = pos;
      acc_nxt = 32'd0;
      minus_nxt = 1'b0;
      do_open = 1'b0;
      if (char_byte == CH_LC_N || char_byte == CH_LC_T || char_byte == CH_LC_F) begin
        mode_nxt = M_LIT;
        exp_nxt = (char_byte == CH_LC_N) ? 2'd0 : (char_byte == CH_LC_T) ? 2'd1 : 2'd2;
        prog_nxt = 3'd1;
      end else if (char_byte == CH_MINUS) begin
        minus_nxt = 1'b1;
        mode_nxt = M_SIGN;
      end else if (char_byte == CH_ZERO) begin
        mode_nxt = M_ZERO;
      end else if (isdig) begin
        acc_nxt = 32'(char_byte - CH_ZERO);
        mode_nxt = M_INT;
      end else if (char_byte == CH_QUOTE) begin
        do_str = 1'b1;
      end else if (char_byte == CH_LBRACK || char_byte == CH_LBRACE) begin
        do_open = 1'b1;
        open_obj = (char_byte == CH_LBRACE);
      end else begin
        do_fail = 1'b1;
        fail_code = ER_START;
      end
    end

    if (do_open) begin
      if (lvl_r >= LW'(NEST_DEPTH)) begin
        do_fail = 1'b1;
        fail_code = ER_DEPTH;
      end else begin
        kwr_en = 1'b1;
        kwr_val = open_obj;
        lvl_nxt = lvl_r + LW'(1);
        res[res_cnt] = mk_res(open_obj ? TK_OBJ_OPEN : TK_ARR_OPEN, ER_OK, 32'd0, 16'(pos),
                              16'd1, 1'b0);
        res_cnt = res_cnt + 2'd1;
        mode_nxt = open_obj ? M_OBJ_FIRST : M_ARR_FIRST;
      end
    end

    if (do_close) begin
      if (lvl_r != '0) begin
        lvl_nxt = lvl_r - LW'(1);
      end
      res[res_cnt] = mk_res(close_obj ? TK_OBJ_CLOSE : TK_ARR_CLOSE, ER_OK, 32'd0, 16'(pos),
                            16'd1, lvl_nxt == '0);
      res_cnt = res_cnt + 2'd1;
      if (lvl_nxt == '0) begin
        fof_nxt = 1'b1;
        mode_nxt = M_IDLE;
      end else begin
        mode_nxt = M_AFTER;
      end
    end

    if (do_str) begin
      mode_nxt = M_STR;
      exp_nxt = {1'b0, str_key};
      beg_nxt = endpos;
      esc_nxt = 3'd0;
    end

    if (do_fail) begin
      res[res_cnt] = mk_res(TK_NONE, fail_code, 32'd0, 16'(pos), 16'd0, 1'b0);
      res_cnt = res_cnt + 2'd1;
      fof_nxt = 1'b1;
      mode_nxt = M_IDLE;
    end

    if (end_of_input) begin
      if (!fof_nxt) begin
        do_fail = 1'b1;
        fail_code = ER_END;
        lidx = (exp_nxt < 2'd3) ? exp_nxt : 2'd0;
        case (mode_nxt)
          M_INT, M_ZERO, M_FRAC: begin
            num_val = minus_nxt ? (32'd0 - acc_nxt) :
                      ((acc_nxt > 32'h7FFFFFFF) ? 32'h7FFFFFFF : acc_nxt);
            res[res_cnt] = mk_res((mode_nxt == M_FRAC) ? TK_FRAC : TK_INT, ER_OK,
                                  (mode_nxt == M_FRAC) ? 32'd0 : num_val, 16'(beg_nxt),
                                  16'(endpos - beg_nxt), lvl_nxt == '0);
            res_cnt = res_cnt + 2'd1;
            do_fail = (lvl_nxt != '0);
          end
          M_SIGN: fail_code = ER_DIGIT;
          M_DOT: fail_code = ER_FRAC;
          M_LIT: fail_code = lit_err(lidx);
          M_STR: fail_code = ER_STRING;
          default: fail_code = ER_END;
        endcase
        if (do_fail) begin
          res[res_cnt] = mk_res(TK_NONE, fail_code, 32'd0, 16'(endpos), 16'd0, 1'b0);
          res_cnt = res_cnt + 2'd1;
        end
      end
      mode_nxt = M_VALUE;
      prog_nxt = 3'd0;
      lvl_nxt = '0;
      exp_nxt = 2'd0;
      pos_nxt = '0;
      beg_nxt = '0;
      acc_nxt = 32'd0;
      minus_nxt = 1'b0;
      esc_nxt = 3'd0;
      fof_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_VALUE;
      prog_r <= 3'd0;
      lvl_r <= '0;
      exp_r <= 2'd0;
      pos_r <= '0;
      beg_r <= '0;
      acc_r <= 32'd0;
      minus_r <= 1'b0;
      esc_r <= 3'd0;
      fof_r <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      prog_r <= prog_nxt;
      lvl_r <= lvl_nxt;
      exp_r <= exp_nxt;
      pos_r <= pos_nxt;
      beg_r <= beg_nxt;
      acc_r <= acc_nxt;
      minus_r <= minus_nxt;
      esc_r <= esc_nxt;
      fof_r <= fof_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kwr_en) begin
      kinds_r[kwr_idx] <= kwr_val;
    end
  end
endmodule

// ===== hw/rtl/jtv_outq.sv =====
// Result register bank: holds the results of one byte and hands them out in order.
// Depends on jtv_pkg.
`timescale 1ns / 1ps
module jtv_outq import jtv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  res_t       res [MAX_RES],
  input  logic [1:0] res_cnt,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res,
  output logic       out_last
);
  res_t slot_r [MAX_RES];
  logic [1:0] cnt_r, idx_r;
  logic [1:0] left;
  logic pop, push;

  assign left = cnt_r - idx_r;
  assign out_valid = (left != 2'd0);
  assign pop = out_valid && out_ready;
  assign in_ready = (left == 2'd0) || ((left == 2'd1) && out_ready);
  assign push = in_valid && in_ready;
  assign out_res = slot_r[idx_r];
  assign out_last = (left == 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (push) begin
      cnt_r <= res_cnt;
      idx_r <= 2'd0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r <= res;
    end
  end
endmodule

// ===== hw/rtl/jtv_checker.sv =====
// Port-level checks of the JSON token validator and their bind to the top level.
// Depends on jtv_pkg and json_token_validator_unit_assert.svh.
`timescale 1ns / 1ps
`include "json_token_validator_unit_assert.svh"
module jtv_checker import jtv_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic [3:0] token_kind,
  input logic [3:0] error_code,
  input logic signed [31:0] int_value,
  input logic [15:0] span_length,
  input logic document_done,
  input logic last_of_run
);
  `JTV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(token_kind) && $stable(error_code) && $stable(int_value) && $stable(last_of_run))
  `JTV_ASSERT_SAME(a_done_is_token, out_valid && document_done,
    error_code == ER_OK && token_kind != TK_NONE && last_of_run)
  `JTV_ASSERT_SAME(a_error_shape, out_valid && error_code != ER_OK,
    token_kind == TK_NONE && int_value == 32'sd0 && span_length == 16'd0)
  `JTV_ASSERT_SAME(a_bracket_len, out_valid && token_kind >= TK_ARR_OPEN,
    span_length == 16'd1 && int_value == 32'sd0)
endmodule

bind json_token_validator_unit jtv_checker u_jtv_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .token_kind(out_ch.token_kind), .error_code(out_ch.error_code),
  .int_value(out_ch.int_value), .span_length(out_ch.span_length),
  .document_done(out_ch.document_done), .last_of_run(out_ch.last_of_run)
);

// ===== sim/tb_json_token_validator_unit.sv =====
// Self-checking testbench for json_token_validator_unit: streams JSON documents one byte
// per item and checks every token and error event against a built-in parser model.
// Depends on jtv_pkg, jtv_if and the RTL of json_token_validator_unit.
`timescale 1ns / 1ps
module tb_json_token_validator_unit import jtv_pkg::*;;

  localparam int NEST_LIMIT = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [3:0] TK_NULL = 4'd1;

  typedef bit [7:0] doc_q_t[$];
  typedef struct {
    res_t r;
    bit last;
  } event_t;

  class token_scoreboard;
    mode_t mode;
    bit [2:0] lit_prog;
    bit kinds[NEST_LIMIT];
    int unsigned nest;
    bit [1:0] flavor;
    bit [15:0] pos;
    bit [15:0] tbeg;
    bit [31:0] mag;
    bit neg;
    bit [2:0] esc;
    bit halted;
    event_t expected_q[$];
    event_t step_q[$];
    int errors;
    int checked;
    string lit_txt[3] = '{"null", "true", "false"};

    function void clear();
      mode = M_VALUE;
      lit_prog = 0;
      foreach (kinds[i]) kinds[i] = 0;
      nest = 0;
      flavor = 0;
      pos = 0;
      tbeg = 0;
      mag = 0;
      neg = 0;
      esc = 0;
      halted = 0;
    endfunction

    function void emit(logic [3:0] kind, logic [3:0] err, logic [31:0] val,
                       logic [15:0] start, logic [15:0] len, logic done);
      event_t e;
      e.r.token_kind = kind;
      e.r.error_code = err;
      e.r.int_value = val;
      e.r.span_start = start;
      e.r.span_length = len;
      e.r.document_done = done;
      e.last = 0;
      if (step_q.size() < MAX_RES) step_q.push_back(e);
    endfunction

    function void abort(logic [3:0] code, logic [15:0] at);
      emit(TK_NONE, code, 0, at, 0, 0);
      halted = 1;
      mode = M_IDLE;
    endfunction

    function void value_done(logic [3:0] kind, logic [31:0] val, logic [15:0] start,
                             logic [15:0] len);
      bit done;
      done = (nest == 0);
      emit(kind, ER_OK, val, start, len, done);
      if (done) begin
        halted = 1;
        mode = M_IDLE;
      end else begin
        mode = M_AFTER;
      end
    endfunction

    function void end_number(bit [15:0] endpos);
      bit [15:0] len;
      bit [31:0] val;
      len = endpos - tbeg;
      if (mode == M_FRAC) begin
        value_done(TK_FRAC, 0, tbeg, len);
        return;
      end
      if (neg) val = 32'd0 - mag;
      else val = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
      value_done(TK_INT, val, tbeg, len);
    endfunction

    function bit blank(bit [7:0] c);
      return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
    endfunction

    function void open_level(bit is_obj, bit [15:0] p);
      if (nest >= NEST_LIMIT) begin
        abort(ER_DEPTH, p);
        return;
      end
      kinds[nest] = is_obj;
      nest++;
      emit(is_obj ? TK_OBJ_OPEN : TK_ARR_OPEN, ER_OK, 0, p, 1, 0);
      mode = is_obj ? M_OBJ_FIRST : M_ARR_FIRST;
    endfunction

    function void close_level(bit is_obj, bit [15:0] p);
      bit done;
      if (nest > 0) nest--;
      done = (nest == 0);
      emit(is_obj ? TK_OBJ_CLOSE : TK_ARR_CLOSE, ER_OK, 0, p, 1, done);
      if (done) begin
        halted = 1;
        mode = M_IDLE;
      end else begin
        mode = M_AFTER;
      end
    endfunction

    function void open_string(bit is_key, bit [15:0] p);
      mode = M_STR;
      flavor = is_key;
      tbeg = p + 16'd1;
      esc = 0;
    endfunction

    function void open_value(bit [7:0] c, bit [15:0] p);
      tbeg = p;
      mag = 0;
      neg = 0;
      if (c == CH_LC_N || c == CH_LC_T || c == CH_LC_F) begin
        mode = M_LIT;
        flavor = (c == CH_LC_N) ? 2'd0 : (c == CH_LC_T) ? 2'd1 : 2'd2;
        lit_prog = 1;
      end else if (c == CH_MINUS) begin
        neg = 1;
        mode = M_SIGN;
      end else if (c == CH_ZERO) begin
        mode = M_ZERO;
      end else if (c > CH_ZERO && c <= CH_NINE) begin
        mag = c - CH_ZERO;
        mode = M_INT;
      end else if (c == CH_QUOTE) begin
        open_string(0, p);
      end else if (c == CH_LBRACK) begin
        open_level(0, p);
      end else if (c == CH_LBRACE) begin
        open_level(1, p);
      end else begin
        abort(ER_START, p);
      end
    endfunction

    function void between_tokens(bit [7:0] c, bit [15:0] p);
      bit is_obj;
      if (blank(c)) return;
      case (mode)
        M_VALUE: open_value(c, p);
        M_ARR_FIRST: begin
          if (c == CH_RBRACK) close_level(0, p);
          else open_value(c, p);
        end
        M_OBJ_FIRST: begin
          if (c == CH_RBRACE) close_level(1, p);
          else if (c == CH_QUOTE) open_string(1, p);
          else abort(ER_OBJ_QUOTE, p);
        end
        M_KEY: begin
          if (c == CH_QUOTE) open_string(1, p);
          else abort(ER_OBJ_QUOTE, p);
        end
        M_COLON: begin
          if (c == CH_COLON) mode = M_VALUE;
          else abort(ER_OBJ_COLON, p);
        end
        M_AFTER: begin
          is_obj = (nest > 0 && nest <= NEST_LIMIT) ? kinds[nest - 1] : 1'b0;
          if (c == (is_obj ? CH_RBRACE : CH_RBRACK)) close_level(is_obj, p);
          else if (c == CH_COMMA) mode = is_obj ? M_KEY : M_VALUE;
          else abort(is_obj ? ER_OBJ_SEP : ER_ARR_SEP, p);
        end
        default: ;
      endcase
    endfunction

    function void take_byte(bit [7:0] c, bit [15:0] p);
      int idx;
      int lit_n;
      bit digit;
      bit [63:0] acc;
      digit = (c >= CH_ZERO && c <= CH_NINE);
      idx = (flavor < 3) ? flavor : 0;
      lit_n = lit_txt[idx].len();
      case (mode)
        M_LIT: begin
          if (lit_prog < lit_n && c == lit_txt[idx][lit_prog]) begin
            lit_prog++;
            if (lit_prog == lit_n) value_done(TK_NULL + 4'(idx), 0, tbeg, 16'(lit_n));
          end else begin
            abort(idx == 0 ? ER_NULL : ER_BOOL, p);
          end
        end
        M_SIGN: begin
          if (c == CH_ZERO) begin
            mode = M_ZERO;
          end else if (digit) begin
            mag = c - CH_ZERO;
            mode = M_INT;
          end else begin
            abort(ER_DIGIT, p);
          end
        end
        M_INT, M_ZERO: begin
          if (mode == M_INT && digit) begin
            acc = 64'(mag) * 10 + (c - CH_ZERO);
            mag = (acc > 64'h8000_0000) ? 32'h8000_0000 : acc[31:0];
          end else if (c == CH_DOT) begin
            mode = M_DOT;
          end else begin
            end_number(p);
            if (!halted) between_tokens(c, p);
          end
        end
        M_DOT: begin
          if (digit) mode = M_FRAC;
          else abort(ER_FRAC, p);
        end
        M_FRAC: begin
          if (!digit) begin
            end_number(p);
            if (!halted) between_tokens(c, p);
          end
        end
        M_STR: begin
          if (esc == 5) esc = (c == CH_LC_U) ? 3'd4 : 3'd0;
          else if (esc > 0) esc--;
          else if (c == CH_BSLASH) esc = 5;
          else if (c == CH_QUOTE) begin
            if (flavor == 1) begin
              emit(TK_KEY, ER_OK, 0, tbeg, p - tbeg, 0);
              mode = M_COLON;
            end else begin
              value_done(TK_STRING, 0, tbeg, p - tbeg);
            end
          end
        end
        M_IDLE: ;
        default: between_tokens(c, p);
      endcase
    endfunction

    function void close_document(bit [15:0] endpos);
      case (mode)
        M_INT, M_ZERO, M_FRAC: begin
          end_number(endpos);
          if (!halted) abort(ER_END, endpos);
        end
        M_SIGN: abort(ER_DIGIT, endpos);
        M_DOT: abort(ER_FRAC, endpos);
        M_LIT: abort((flavor == 0 || flavor == 3) ? ER_NULL : ER_BOOL, endpos);
        M_STR: abort(ER_STRING, endpos);
        default: abort(ER_END, endpos);
      endcase
    endfunction

    function void note_input(bit [7:0] c, bit last);
      bit [15:0] p;
      p = pos;
      pos = p + 16'd1;
      step_q.delete();
      if (!halted) take_byte(c, p);
      if (last) begin
        if (!halted) close_document(p + 16'd1);
        clear();
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(res_t got, bit last);
      event_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result, token_kind", got.token_kind, 0);
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.token_kind !== e.r.token_kind) report("token_kind", got.token_kind, e.r.token_kind);
      if (got.error_code !== e.r.error_code) report("error_code", got.error_code, e.r.error_code);
      if (got.int_value !== e.r.int_value) report("int_value", got.int_value, e.r.int_value);
      if (got.span_start !== e.r.span_start) report("span_start", got.span_start, e.r.span_start);
      if (got.span_length !== e.r.span_length)
        report("span_length", got.span_length, e.r.span_length);
      if (got.document_done !== e.r.document_done)
        report("document_done", got.document_done, e.r.document_done);
      if (last !== e.last) report("last_of_run", last, e.last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  jtv_in_if in_ch();
  jtv_out_if out_ch();
  token_scoreboard sb;
  int in_idle;
  int out_idle;
  int stall_count;
  int docs_sent;
  int bytes_sent;

  json_token_validator_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= out_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result('{out_ch.token_kind, out_ch.error_code, out_ch.int_value,
                        out_ch.span_start, out_ch.span_length, out_ch.document_done},
                      out_ch.last_of_run);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function automatic doc_q_t text_doc(string s);
    doc_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic void add_blanks(ref doc_q_t q);
    bit [7:0] pick[4] = '{CH_SPACE, CH_CR, CH_LF, CH_TAB};
    if ($urandom_range(3) == 0) q.push_back(pick[$urandom_range(3)]);
  endfunction

  function automatic void add_string(ref doc_q_t q);
    int n;
    q.push_back(CH_QUOTE);
    n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: begin
          q.push_back(CH_BSLASH);
          q.push_back(8'($urandom_range(32, 126)));
        end
        1: begin
          q.push_back(CH_BSLASH);
          q.push_back(CH_LC_U);
          repeat (4) q.push_back(8'($urandom_range(32, 126)));
        end
        default: q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
    q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_value(int depth, ref doc_q_t q);
    int n;
    int pick;
    string lit;
    add_blanks(q);
    pick = (depth >= 3) ? $urandom_range(2) : $urandom_range(4);
    case (pick)
      0: begin
        case ($urandom_range(2))
          0: lit = "null";
          1: lit = "true";
          default: lit = "false";
        endcase
        for (int i = 0; i < lit.len(); i++) q.push_back(lit[i]);
      end
      1: begin
        if ($urandom_range(1)) q.push_back(CH_MINUS);
        if ($urandom_range(4) == 0) begin
          q.push_back(CH_ZERO);
        end else begin
          q.push_back(8'($urandom_range(8'h31, CH_NINE)));
          n = $urandom_range(11);
          repeat (n) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(2) == 0) begin
          q.push_back(CH_DOT);
          repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
      end
      2: add_string(q);
      3: begin
        q.push_back(CH_LBRACK);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(CH_COMMA);
          add_value(depth + 1, q);
          add_blanks(q);
        end
        q.push_back(CH_RBRACK);
      end
      default: begin
        q.push_back(CH_LBRACE);
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) q.push_back(CH_COMMA);
          add_blanks(q);
          add_string(q);
          add_blanks(q);
          q.push_back(CH_COLON);
          add_value(depth + 1, q);
          add_blanks(q);
        end
        q.push_back(CH_RBRACE);
      end
    endcase
  endfunction

  function automatic doc_q_t random_doc();
    doc_q_t q;
    int k;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(255)));
      return q;
    end
    add_value(0, q);
    case ($urandom_range(7))
      0: begin
        k = $urandom_range(q.size() - 1);
        q[k] = 8'($urandom_range(255));
      end
      1: while (q.size() > 1 && $urandom_range(2) != 0) void'(q.pop_back());
      2: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(255)));
      default: ;
    endcase
    return q;
  endfunction

  task automatic send_doc(doc_q_t q);
    for (int i = 0; i < q.size(); i++) begin
      while ($urandom_range(99) < in_idle) begin
        in_ch.valid = 0;
        @(negedge clk);
      end
      in_ch.valid = 1;
      in_ch.char_byte = q[i];
      in_ch.end_of_input = (i == q.size() - 1);
      do @(posedge clk); while (!in_ch.ready);
      sb.note_input(q[i], i == q.size() - 1);
      bytes_sent++;
      @(negedge clk);
    end
    in_ch.valid = 0;
    docs_sent++;
  endtask

  task automatic random_docs(int byte_target);
    int stop_at;
    stop_at = bytes_sent + byte_target;
    while (bytes_sent < stop_at) send_doc(random_doc());
  endtask

  initial begin
    string directed[$];
    doc_q_t q;
    sb = new();
    sb.clear();
    in_idle = 22;
    out_idle = 87;
    stall_count = 0;
    docs_sent = 0;
    bytes_sent = 0;
    in_ch.valid = 0;
    in_ch.char_byte = 0;
    in_ch.end_of_input = 0;
    rst_n = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    directed = '{"null", "true", "false", "-0", "2147483648", "-2147483649", "1.5",
                 "\"a\\u12\"4b\\\"c\"", "{\"k\" : [1, -2.25, {}], \"z\":\"\"}", "[]",
                 "nul", "tx", "-a", "1.x", "\"abc", "[1 2]", "{1}", "{\"a\" 1}",
                 "{\"a\":1 2}", "[1}", "{\"a\":0]", "x", " \t\r\n", "[12", "[01]",
                 "7 junk"};
    foreach (directed[i]) send_doc(text_doc(directed[i]));
    q.delete();
    repeat (NEST_LIMIT + 1) q.push_back(CH_LBRACK);
    send_doc(q);
    q.delete();
    q.push_back(8'hFF);
    q.push_back(8'h00);
    send_doc(q);
    random_docs(8);

    in_idle = 87;
    out_idle = 22;
    random_docs(8);

    in_idle = 0;
    out_idle = 0;
    random_docs(8);

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d documents (%0d bytes) through directed, random and nesting-limit cases.",
             docs_sent, bytes_sent);
    $display("Checked %0d results with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
